// ===== design/mccr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI control change remapper: shared definitions
// Payload types, opcode and command codes, sizes used across the block.
// ----------------------------------------------------------------------------
package mccr_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// power of two
	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

	localparam logic [3:0] OP_NOTE_OFF  = 4'd0;
	localparam logic [3:0] OP_NOTE_ON   = 4'd1;
	localparam logic [3:0] OP_KEY_PRESS = 4'd2;
	localparam logic [3:0] OP_CTRL      = 4'd3;
	localparam logic [3:0] OP_PROGRAM   = 4'd4;
	localparam logic [3:0] OP_CH_PRESS  = 4'd5;
	localparam logic [3:0] OP_BEND      = 4'd6;
	localparam logic [3:0] OP_SYSEX     = 4'd7;
	localparam logic [3:0] OP_START     = 4'd8;

	localparam logic [1:0] KIND_RAW  = 2'd0;
	localparam logic [1:0] KIND_NRPN = 2'd1;
	localparam logic [1:0] KIND_GS   = 2'd2;
	localparam logic [1:0] KIND_MIC  = 2'd3;

	localparam logic [13:0] EFFECT_PARAM = 14'h375F;
	localparam logic [6:0]  EFFECT_RESET = 7'h3B;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [3:0]  channel;
		logic [6:0]  data_first;
		logic [6:0]  data_second;
		logic [13:0] bend_amount;
		logic [7:0]  sysex_data;
	} msg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} stream_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  raw_last;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [3:0]  ch;
		logic [13:0] param;
		logic [6:0]  val;
		logic [6:0]  cs;
	} cmd_t;

endpackage
`default_nettype wire

// ===== design/mccr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI control change remapper: front end
// Classifies each message, updates program store and effect bits, and
// builds one byte-sequence command per message that produces output.
// ----------------------------------------------------------------------------
module mccr_front
	import mccr_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic take,
	input  wire  msg_t msg,
	output logic       push,
	output cmd_t       cmd
);

	localparam logic [6:0] CC_BANK      = 7'd0;
	localparam logic [6:0] CC_PROG_DOWN = 7'd14;
	localparam logic [6:0] CC_PROG_UP   = 7'd15;
	localparam logic [6:0] CC_FX_B5     = 7'd36;
	localparam logic [6:0] CC_FX_B4     = 7'd37;
	localparam logic [6:0] CC_FX_B3     = 7'd38;
	localparam logic [6:0] CC_FX_B2     = 7'd39;
	localparam logic [6:0] CC_FX_B6     = 7'd40;
	localparam logic [6:0] CC_FX_B10    = 7'd41;
	localparam logic [6:0] CC_GS_34     = 7'd42;
	localparam logic [6:0] CC_GS_3D     = 7'd43;
	localparam logic [6:0] CC_GS_3E     = 7'd44;
	localparam logic [6:0] CC_GS_3C     = 7'd45;
	localparam logic [6:0] CC_GS_3B     = 7'd46;
	localparam logic [6:0] CC_MIC       = 7'd47;

	function automatic logic [14:0] nrpn_lookup(input logic [6:0] ctl);
		logic [14:0] r;
		r = '0;
		case (ctl)
			7'd16: r = {1'b1, 14'h3707};
			7'd17: r = {1'b1, 14'h3724};
			7'd18: r = {1'b1, 14'h3720};
			7'd20: r = {1'b1, 14'h3728};
			7'd21: r = {1'b1, 14'h3729};
			7'd22: r = {1'b1, 14'h372A};
			7'd33: r = {1'b1, 14'h3726};
			7'd24: r = {1'b1, 14'h3700};
			7'd25: r = {1'b1, 14'h3701};
			7'd26: r = {1'b1, 14'h3702};
			7'd27: r = {1'b1, 14'h3703};
			7'd28: r = {1'b1, 14'h3708};
			7'd29: r = {1'b1, 14'h3709};
			7'd30: r = {1'b1, 14'h370A};
			7'd31: r = {1'b1, 14'h370B};
			7'd34: r = {1'b1, 14'h372C};
			7'd35: r = {1'b1, 14'h372D};
			default: r = '0;
		endcase
		return r;
	endfunction

	logic [6:0] prog_q [NUM_CHANNELS];
	logic [6:0] effect_q;

	logic              ch_ok;
	logic [CH_IDX_W-1:0] ch_idx;
	logic [6:0]        prog_cur;
	logic [6:0]        prog_n;
	logic              prog_we;
	logic [6:0]        effect_n;
	logic [14:0]       nrpn_hit;
	logic [6:0]        gs_a2;
	logic [6:0]        gs_sum;
	logic [7:0]        status;
	logic              hi;

	assign ch_ok    = {1'b0, msg.channel} < 5'(NUM_CHANNELS);
	assign ch_idx   = msg.channel[CH_IDX_W-1:0];
	assign prog_cur = prog_q[ch_idx];
	assign nrpn_hit = nrpn_lookup(msg.data_first);
	assign hi       = msg.data_second >= 7'd64;
	// status nibble follows opcode: 8 + opcode for all channel messages
	assign status   = {1'b1, msg.opcode[2:0], msg.channel};

	always_comb begin
		case (msg.data_first)
			CC_GS_34: gs_a2 = 7'h34;
			CC_GS_3D: gs_a2 = 7'h3D;
			CC_GS_3E: gs_a2 = 7'h3E;
			CC_GS_3C: gs_a2 = 7'h3C;
			default:  gs_a2 = 7'h3B;
		endcase
		gs_sum = 7'(7'h41 + gs_a2 + msg.data_second);
	end

	always_comb begin
		push     = 1'b0;
		cmd      = '0;
		prog_we  = 1'b0;
		prog_n   = prog_cur;
		effect_n = effect_q;
		case (msg.opcode)
			OP_NOTE_OFF, OP_NOTE_ON, OP_KEY_PRESS: begin
				push         = 1'b1;
				cmd.kind     = KIND_RAW;
				cmd.raw_last = 2'd2;
				cmd.b0       = status;
				cmd.b1       = {1'b0, msg.data_first};
				cmd.b2       = {1'b0, msg.data_second};
			end
			OP_PROGRAM: begin
				push         = 1'b1;
				prog_we      = ch_ok;
				prog_n       = msg.data_first;
				cmd.kind     = KIND_RAW;
				cmd.raw_last = 2'd1;
				cmd.b0       = status;
				cmd.b1       = {1'b0, msg.data_first};
			end
			OP_CH_PRESS: begin
				push         = 1'b1;
				cmd.kind     = KIND_RAW;
				cmd.raw_last = 2'd1;
				cmd.b0       = status;
				cmd.b1       = {1'b0, msg.data_second};
			end
			OP_BEND: begin
				push         = 1'b1;
				cmd.kind     = KIND_RAW;
				cmd.raw_last = 2'd2;
				cmd.b0       = status;
				cmd.b1       = {1'b0, msg.bend_amount[6:0]};
				cmd.b2       = {1'b0, msg.bend_amount[13:7]};
			end
			OP_SYSEX: begin
				push         = 1'b1;
				cmd.kind     = KIND_RAW;
				cmd.raw_last = 2'd0;
				cmd.b0       = msg.sysex_data;
			end
			OP_START: begin
				push      = 1'b1;
				cmd.kind  = KIND_NRPN;
				cmd.param = EFFECT_PARAM;
				cmd.val   = effect_q;
			end
			OP_CTRL: begin
				case (msg.data_first)
					CC_BANK: begin
						push         = (msg.data_second == 7'd0) || (msg.data_second == 7'd1);
						cmd.kind     = KIND_RAW;
						cmd.raw_last = 2'd2;
						cmd.b0       = status;
						cmd.b2       = (msg.data_second == 7'd1) ? 8'd127 : 8'd0;
					end
					CC_PROG_DOWN, CC_PROG_UP: begin
						push         = hi && ch_ok;
						prog_we      = hi && ch_ok;
						prog_n       = (msg.data_first == CC_PROG_UP) ?
							7'(prog_cur + 7'd1) : 7'(prog_cur - 7'd1);
						cmd.kind     = KIND_RAW;
						cmd.raw_last = 2'd1;
						cmd.b0       = {4'hC, msg.channel};
						cmd.b1       = {1'b0, prog_n};
					end
					CC_FX_B5, CC_FX_B4, CC_FX_B3, CC_FX_B2, CC_FX_B6, CC_FX_B10: begin
						case (msg.data_first)
							CC_FX_B5: effect_n[5] = hi;
							CC_FX_B4: effect_n[4] = hi;
							CC_FX_B3: effect_n[3] = hi;
							CC_FX_B2: effect_n[2] = hi;
							CC_FX_B6: effect_n[6] = hi;
							default: begin
								effect_n[1] = msg.data_second >= 7'd43;
								effect_n[0] = msg.data_second >= 7'd86;
							end
						endcase
						push      = 1'b1;
						cmd.kind  = KIND_NRPN;
						cmd.param = EFFECT_PARAM;
						cmd.val   = effect_n;
					end
					CC_GS_34, CC_GS_3D, CC_GS_3E, CC_GS_3C, CC_GS_3B: begin
						push      = 1'b1;
						cmd.kind  = KIND_GS;
						cmd.param = {7'd0, gs_a2};
						cmd.val   = msg.data_second;
						cmd.cs    = 7'(7'd0 - gs_sum);
					end
					CC_MIC: begin
						push     = 1'b1;
						cmd.kind = KIND_MIC;
						cmd.val  = {6'd0, hi};
					end
					default: begin
						push = 1'b1;
						if (nrpn_hit[14]) begin
							cmd.kind  = KIND_NRPN;
							cmd.ch    = msg.channel;
							cmd.param = nrpn_hit[13:0];
							cmd.val   = msg.data_second;
						end else begin
							cmd.kind     = KIND_RAW;
							cmd.raw_last = 2'd2;
							cmd.b0       = status;
							cmd.b1       = {1'b0, msg.data_first};
							cmd.b2       = {1'b0, msg.data_second};
						end
					end
				endcase
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_q <= EFFECT_RESET;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				prog_q[i] <= '0;
			end
		end else if (take) begin
			effect_q <= effect_n;
			if (prog_we) begin
				prog_q[ch_idx] <= prog_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/mccr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI control change remapper: command queue
// Small FIFO of byte-sequence commands between front end and sequencer.
// ----------------------------------------------------------------------------
module mccr_queue
	import mccr_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic push,
	input  wire  cmd_t push_cmd,
	output logic       full,
	input  wire  logic pop,
	output logic       head_valid,
	output cmd_t       head
);

	cmd_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign full       = count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= QUEUE_AW'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= QUEUE_AW'(rd_ptr_q + 1'b1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= (QUEUE_AW + 1)'(count_q + 1'b1);
				2'b01:   count_q <= (QUEUE_AW + 1)'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/mccr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI control change remapper: byte sequencer
// Expands each command into its bytes, one per cycle while stream_ready allows, into an output register.
// ----------------------------------------------------------------------------
module mccr_back
	import mccr_pkg::*;
(
	input  wire  logic    clk,
	input  wire  logic    arst_n,
	input  wire  logic    head_valid,
	input  wire  cmd_t    head,
	output logic          pop,
	output logic          stream_valid,
	input  wire  logic    stream_ready,
	output stream_t       stream_data
);

	localparam logic [7:0] MIC_MSG [16] = '{
		8'hF0, 8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h12, 8'h33,
		8'h77, 8'h14, 8'h04, 8'h07, 8'h07, 8'h0D, 8'h00, 8'hF7
	};

	function automatic logic [3:0] last_idx(input cmd_t c);
		logic [3:0] r;
		case (c.kind)
			KIND_RAW:  r = {2'b00, c.raw_last};
			KIND_NRPN: r = 4'd14;
			KIND_GS:   r = 4'd11;
			default:   r = 4'd15;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] gen_byte(input cmd_t c, input logic [3:0] idx);
		logic [7:0] r;
		r = 8'h00;
		case (c.kind)
			KIND_RAW: begin
				case (idx)
					4'd0:    r = c.b0;
					4'd1:    r = c.b1;
					default: r = c.b2;
				endcase
			end
			KIND_NRPN: begin
				case (idx)
					4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = {4'hB, c.ch};
					4'd1, 4'd10: r = 8'd99;
					4'd4, 4'd13: r = 8'd98;
					4'd7:        r = 8'd6;
					4'd2:        r = {1'b0, c.param[13:7]};
					4'd5:        r = {1'b0, c.param[6:0]};
					4'd8:        r = {1'b0, c.val};
					4'd11, 4'd14: r = 8'h7F;
					default:     r = 8'h00;
				endcase
			end
			KIND_GS: begin
				case (idx)
					4'd0:    r = 8'hF0;
					4'd1:    r = 8'h41;
					4'd3:    r = 8'h42;
					4'd4:    r = 8'h12;
					4'd5:    r = 8'h40;
					4'd6:    r = 8'h01;
					4'd7:    r = {1'b0, c.param[6:0]};
					4'd9:    r = {1'b0, c.val};
					4'd10:   r = {1'b0, c.cs};
					4'd11:   r = 8'hF7;
					default: r = 8'h00;
				endcase
			end
			default: begin
				r = (idx == 4'd10) ? (c.val[0] ? 8'h04 : 8'h00) : MIC_MSG[idx];
			end
		endcase
		return r;
	endfunction

	cmd_t       cur_q;
	logic [3:0] idx_q;
	logic       busy_q;
	logic       valid_q;
	stream_t    data_q;

	cmd_t       src;
	logic [3:0] sidx;
	logic       have;
	logic       adv;
	logic       step;
	logic       at_end;

	assign src    = busy_q ? cur_q : head;
	assign sidx   = busy_q ? idx_q : 4'd0;
	assign have   = busy_q || head_valid;
	assign adv    = !valid_q || stream_ready;
	assign step   = adv && have;
	assign pop    = step && !busy_q;
	assign at_end = sidx == last_idx(src);

	assign stream_valid = valid_q;
	assign stream_data  = data_q;

	always_ff @(posedge clk) begin
		if (step) begin
			data_q.out_byte <= gen_byte(src, sidx);
			data_q.last     <= at_end;
			cur_q           <= src;
			idx_q           <= 4'(sidx + 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= have;
			if (have) begin
				busy_q <= !at_end;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/midi_control_change_remapper_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI control change remapper
// Turns decoded MIDI messages into a raw MIDI byte stream with remapping.
// The first byte of a message passes through the command queue and then the
// output register. The output carries one byte per cycle while stream_ready
// allows; a message expands to 1 to 16 bytes. Messages are taken one per
// cycle while the four-entry command queue has room.
// Reset: program store to zero, effect bits to 0x3B, queue and output empty.
// ----------------------------------------------------------------------------
module midi_control_change_remapper_unit
	import mccr_pkg::*;
(
	input  wire  logic    clk,
	input  wire  logic    arst_n,
	input  wire  logic    msg_valid,
	output logic          msg_ready,
	input  wire  msg_t    msg,
	output logic          stream_valid,
	input  wire  logic    stream_ready,
	output stream_t       stream_data
);

	logic full;
	logic take;
	logic push;
	cmd_t cmd;
	logic pop;
	logic head_valid;
	cmd_t head;

	assign msg_ready = !full;
	assign take      = msg_valid && msg_ready;

	mccr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.msg    (msg),
		.push   (push),
		.cmd    (cmd)
	);

	mccr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push && take),
		.push_cmd   (cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	mccr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.stream_valid (stream_valid),
		.stream_ready (stream_ready),
		.stream_data  (stream_data)
	);

endmodule
`default_nettype wire
